// ----- rtl/plq_pkg.sv -----
// Shared constants and helpers for the log-odds base quality pipeline.
package plq_pkg;

    // Fixed field widths
    localparam int PROB_W              = 17;
    localparam int QUAL_W              = 15;
    localparam int PROB_FRAC_BITS_DEF  = 16;

    // Probability floor of 1e-3, rounded to nearest
    localparam int FLOOR_RND           = 500;
    localparam int FLOOR_DEN           = 1000;

    // log2 datapath: Q1.31 mantissa, 30 fraction bits of result
    localparam int LOG_FRAC            = 30;
    localparam int M_W                 = 32;

    // 2560*log10(2) as 50504453 / 2^16
    localparam int DB_SCALE_W          = 26;
    localparam logic [DB_SCALE_W-1:0] DB_SCALE = 26'd50504453;
    localparam int DB_SCALE_SHIFT      = 16;
    localparam int PROD_SPLIT          = 17;

    // +-40 dB in 1/256 dB
    localparam int QUAL_LIMIT          = 10240;

    function automatic int floor_term(input int frac_bits);
        int f;
        f = ((1 << frac_bits) + FLOOR_RND) / FLOOR_DEN;
        return (f == 0) ? 1 : f;
    endfunction

    function automatic int log_w(input int x_w);
        return $clog2(x_w) + LOG_FRAC;
    endfunction

endpackage

// ----- rtl/plq_log2_pipe.sv -----
// Pipelined fixed-point log2: one normalize stage, then one squaring stage per fraction bit.
module plq_log2_pipe #(
    parameter int X_W = 20
) (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [X_W-1:0]                     x,
    output logic [plq_pkg::log_w(X_W)-1:0]     log_out
);

    localparam int LOG_FRAC = plq_pkg::LOG_FRAC;
    localparam int M_W      = plq_pkg::M_W;
    localparam int MSB_W    = $clog2(X_W);
    localparam int SH_W     = $clog2(M_W);

    logic [MSB_W-1:0]    msb;
    logic [SH_W-1:0]     norm_sh;

    logic [M_W-1:0]      m_reg    [0:LOG_FRAC-1];
    logic [LOG_FRAC-1:0] frac_reg [0:LOG_FRAC];
    logic [MSB_W-1:0]    msb_reg  [0:LOG_FRAC];

    // truncated square of each stage's mantissa, 2.0 lands in the top bit
    logic [M_W:0]        sq_hi    [0:LOG_FRAC-1];

    // leading one; x is never zero here
    always_comb begin
        msb = '0;
        for (int b = 0; b < X_W; b++) begin
            if (x[b]) begin
                msb = MSB_W'(b);
            end
        end
        norm_sh = SH_W'(M_W - 1) - SH_W'(msb);
    end

    always_comb begin
        logic [2*M_W-1:0] sq;
        for (int k = 0; k < LOG_FRAC; k++) begin
            sq       = m_reg[k] * m_reg[k];
            sq_hi[k] = sq[2*M_W-1:M_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]    <= M_W'(x) << norm_sh;
            frac_reg[0] <= '0;
            msb_reg[0]  <= msb;
            for (int k = 0; k < LOG_FRAC; k++) begin
                frac_reg[k+1] <= frac_reg[k] |
                                 (LOG_FRAC'(sq_hi[k][M_W]) << (LOG_FRAC - 1 - k));
                msb_reg[k+1]  <= msb_reg[k];
            end
            for (int k = 0; k < LOG_FRAC - 1; k++) begin
                m_reg[k+1] <= sq_hi[k][M_W] ? sq_hi[k][M_W:1] : sq_hi[k][M_W-1:0];
            end
        end
    end

    assign log_out = {msb_reg[LOG_FRAC], frac_reg[LOG_FRAC]};

endmodule

// ----- rtl/probability_to_log_odds_quality.sv -----
// Top level: four base probabilities in, four log-odds qualities in 1/256 dB out.
//
// Usage
//   Input channel s_valid/s_ready carries one read position per beat: the
//   probabilities of A, C, G, T, unsigned, 2^PROB_FRAC_BITS meaning 1.0.
//   Output channel m_valid/m_ready carries one beat per input beat, in order,
//   with qual = 10*log10(a/(S-a)) per base, signed 1/256 dB, clamped to +-40 dB.
//   Throughput: one beat per cycle, sustained while m_ready stays high.
//   Pipeline: the log2 units spend one pipeline stage per fraction bit
//   (a 32x32 squaring each), plus sum, difference and scale stages.
//   Stall: the output register holds a result while m_ready is low; a skid
//   register catches the one beat already in flight, and the whole pipe then
//   freezes (s_ready low) until the skid drains. Nothing is lost or repeated.
//   Reset (aresetn low at a clock edge): all valid bits clear, pipe empties,
//   s_ready is held low while aresetn is low and rises with its release.
module probability_to_log_odds_quality #(
    parameter int PROB_FRAC_BITS = plq_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [plq_pkg::PROB_W-1:0]        s_prob_a,
    input  logic [plq_pkg::PROB_W-1:0]        s_prob_c,
    input  logic [plq_pkg::PROB_W-1:0]        s_prob_g,
    input  logic [plq_pkg::PROB_W-1:0]        s_prob_t,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [plq_pkg::QUAL_W-1:0] m_qual_a,
    output logic signed [plq_pkg::QUAL_W-1:0] m_qual_c,
    output logic signed [plq_pkg::QUAL_W-1:0] m_qual_g,
    output logic signed [plq_pkg::QUAL_W-1:0] m_qual_t
);

    localparam int PROB_W   = plq_pkg::PROB_W;
    localparam int QUAL_W   = plq_pkg::QUAL_W;
    localparam int LOG_FRAC = plq_pkg::LOG_FRAC;

    // Saturated probability is wide enough for both the port and 1.0
    localparam int SAT_W = (PROB_FRAC_BITS + 1 > PROB_W) ? PROB_FRAC_BITS + 1 : PROB_W;
    localparam int A_W   = SAT_W + 1;
    localparam int S_W   = A_W + 2;
    localparam int LOG_W = plq_pkg::log_w(S_W);

    localparam logic [SAT_W-1:0] ONE_PROB = SAT_W'(1) << PROB_FRAC_BITS;
    localparam logic [A_W-1:0]   FLOOR_A  = A_W'(plq_pkg::floor_term(PROB_FRAC_BITS));

    localparam int LO_W    = plq_pkg::PROD_SPLIT;
    localparam int HI_W    = LOG_W - LO_W;
    localparam int SC_W    = plq_pkg::DB_SCALE_W;
    localparam int PROD_W  = LOG_W + SC_W;
    localparam int SHIFT   = LOG_FRAC + plq_pkg::DB_SCALE_SHIFT;
    localparam int MAG_W   = PROD_W - SHIFT;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (SHIFT - 1);
    localparam logic [MAG_W-1:0]  MAG_LIMIT = MAG_W'(plq_pkg::QUAL_LIMIT);
    localparam logic signed [QUAL_W-1:0] QLIM = QUAL_W'(plq_pkg::QUAL_LIMIT);

    // sum stage, normalize, LOG_FRAC squarings, difference, product
    localparam int PIPE_DEPTH = LOG_FRAC + 4;

    // ---------------------------------------------------------------
    // Pipe control: one enable for every stage, held off by the skid
    // ---------------------------------------------------------------
    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  skid_valid_reg;
    logic                  out_valid_reg;
    logic                  pipe_out_valid;

    assign en             = !skid_valid_reg;
    assign s_ready        = en && aresetn;
    assign pipe_out_valid = en && valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: clip to 1.0, add floor, form S
    // ---------------------------------------------------------------
    logic [PROB_W-1:0] prob_in [0:3];
    logic [A_W-1:0]    a_next  [0:3];
    logic [S_W-1:0]    sum_next;
    logic [A_W-1:0]    a_reg   [0:3];
    logic [S_W-1:0]    sum_reg;

    assign prob_in[0] = s_prob_a;
    assign prob_in[1] = s_prob_c;
    assign prob_in[2] = s_prob_g;
    assign prob_in[3] = s_prob_t;

    always_comb begin
        logic [SAT_W-1:0] p_ext;
        sum_next = '0;
        for (int i = 0; i < 4; i++) begin
            p_ext     = SAT_W'(prob_in[i]);
            a_next[i] = A_W'((p_ext > ONE_PROB) ? ONE_PROB : p_ext) + FLOOR_A;
            sum_next  = sum_next + S_W'(a_next[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= a_next;
            sum_reg <= sum_next;
        end
    end

    // ---------------------------------------------------------------
    // log2 of a and of S - a, eight units in parallel
    // ---------------------------------------------------------------
    logic [LOG_W-1:0] log_a [0:3];
    logic [LOG_W-1:0] log_b [0:3];

    genvar g;
    for (g = 0; g < 4; g++) begin : g_base
        logic [S_W-1:0] a_ext;
        logic [S_W-1:0] rest;

        assign a_ext = S_W'(a_reg[g]);
        assign rest  = sum_reg - a_ext;

        plq_log2_pipe #(
            .X_W     (S_W)
        ) u_log_a (
            .aclk    (aclk),
            .en      (en),
            .x       (a_ext),
            .log_out (log_a[g])
        );

        plq_log2_pipe #(
            .X_W     (S_W)
        ) u_log_b (
            .aclk    (aclk),
            .en      (en),
            .x       (rest),
            .log_out (log_b[g])
        );
    end

    // ---------------------------------------------------------------
    // Difference of logs, then scale split into two partial products
    // ---------------------------------------------------------------
    logic [LOG_W-1:0]        d_reg    [0:3];
    logic                    neg_reg  [0:3];
    logic [LO_W+SC_W-1:0]    plo_reg  [0:3];
    logic [HI_W+SC_W-1:0]    phi_reg  [0:3];
    logic                    neg2_reg [0:3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                neg_reg[i]  <= log_a[i] < log_b[i];
                d_reg[i]    <= (log_a[i] < log_b[i]) ? log_b[i] - log_a[i]
                                                     : log_a[i] - log_b[i];
                plo_reg[i]  <= (LO_W+SC_W)'(d_reg[i][LO_W-1:0]) *
                               (LO_W+SC_W)'(plq_pkg::DB_SCALE);
                phi_reg[i]  <= (HI_W+SC_W)'(d_reg[i][LOG_W-1:LO_W]) *
                               (HI_W+SC_W)'(plq_pkg::DB_SCALE);
                neg2_reg[i] <= neg_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------
    // Final: combine, round half away from zero, clamp, apply sign
    // ---------------------------------------------------------------
    logic signed [QUAL_W-1:0] qual_next [0:3];

    always_comb begin
        logic [PROD_W-1:0] prod;
        logic [MAG_W-1:0]  mag;
        logic [QUAL_W-1:0] mag_c;
        for (int i = 0; i < 4; i++) begin
            prod  = (PROD_W'(phi_reg[i]) << LO_W) + PROD_W'(plo_reg[i]) + ROUND;
            mag   = prod[PROD_W-1:SHIFT];
            mag_c = (mag > MAG_LIMIT) ? QUAL_W'(MAG_LIMIT) : QUAL_W'(mag);
            qual_next[i] = neg2_reg[i] ? -$signed(mag_c) : $signed(mag_c);
        end
    end

    // ---------------------------------------------------------------
    // Output register plus skid register
    // ---------------------------------------------------------------
    logic signed [QUAL_W-1:0] out_q_reg  [0:3];
    logic signed [QUAL_W-1:0] skid_q_reg [0:3];
    logic                     out_take;

    assign out_take = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= pipe_out_valid;
            end
        end else if (pipe_out_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take) begin
            if (skid_valid_reg) begin
                out_q_reg <= skid_q_reg;
            end else begin
                out_q_reg <= qual_next;
            end
        end else if (pipe_out_valid) begin
            skid_q_reg <= qual_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_qual_a = out_q_reg[0];
    assign m_qual_c = out_q_reg[1];
    assign m_qual_g = out_q_reg[2];
    assign m_qual_t = out_q_reg[3];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_ready) |=> (!s_ready && m_valid))
        else $error("pipe advanced while output stalled with skid full");

    a_qual_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_qual_a >= -QLIM && m_qual_a <= QLIM &&
                     m_qual_c >= -QLIM && m_qual_c <= QLIM &&
                     m_qual_g >= -QLIM && m_qual_g <= QLIM &&
                     m_qual_t >= -QLIM && m_qual_t <= QLIM))
        else $error("quality outside +-40 dB");

endmodule

// ----- dv/tb.sv -----
// Testbench for probability_to_log_odds_quality: self-checking stream test with a bit-exact predictor.
`timescale 1ns / 100ps

module tb;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          PROB_W      = plq_pkg::PROB_W;
    localparam int          QUAL_W      = plq_pkg::QUAL_W;
    localparam int          LOG_FRAC    = plq_pkg::LOG_FRAC;
    localparam int          QUAL_LIMIT  = plq_pkg::QUAL_LIMIT;
    localparam int          FLOOR_RND   = plq_pkg::FLOOR_RND;
    localparam int          FLOOR_DEN   = plq_pkg::FLOOR_DEN;
    localparam logic [plq_pkg::DB_SCALE_W-1:0] DB_SCALE = plq_pkg::DB_SCALE;
    localparam int          FRAC_BITS   = plq_pkg::PROB_FRAC_BITS_DEF;
    localparam logic [63:0] PROB_ONE    = 64'd1 << FRAC_BITS;
    localparam int          SCALE_SHIFT = LOG_FRAC + plq_pkg::DB_SCALE_SHIFT;
    localparam logic [63:0] FIELD_MAX   = (64'd1 << PROB_W) - 1;
    // the tail wait outlasts the pipe latency and leaves some margin
    localparam int          TAIL_CYCLES = LOG_FRAC + 16;
    // no handshake on either side for this long means the block is stuck
    localparam int          STUCK_LIMIT = 2000;
    localparam int          N_RANDOM    = 800;

    typedef struct packed {
        logic [PROB_W-1:0] a;
        logic [PROB_W-1:0] c;
        logic [PROB_W-1:0] g;
        logic [PROB_W-1:0] t;
    } prob_beat_t;

    typedef logic signed [QUAL_W-1:0] qual_t;

    typedef struct packed {
        qual_t a;
        qual_t c;
        qual_t g;
        qual_t t;
    } qual_beat_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic aclk;
    logic aresetn = 1'b0;

    logic       s_valid  = 1'b0;
    logic       s_ready;
    prob_beat_t cur_beat = '0;
    logic       m_valid;
    logic       m_ready  = 1'b0;
    qual_t      m_qual_a, m_qual_c, m_qual_g, m_qual_t;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    probability_to_log_odds_quality #(
        .PROB_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_prob_a (cur_beat.a),
        .s_prob_c (cur_beat.c),
        .s_prob_g (cur_beat.g),
        .s_prob_t (cur_beat.t),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_qual_a (m_qual_a),
        .m_qual_c (m_qual_c),
        .m_qual_g (m_qual_g),
        .m_qual_t (m_qual_t)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // log2(x) with LOG_FRAC fraction bits: normalize to Q1.31, then one
    // truncated squaring per fraction bit; a square >= 2.0 sets the bit.
    function automatic logic [63:0] log2_q30(input logic [63:0] x);
        int          msb;
        int          i;
        logic [63:0] m;
        logic [63:0] frac;
        if (x == 0)
            return 64'd0;
        msb = 0;
        while (msb < 62 && (x >> (msb + 1)) != 0)
            msb++;
        if (msb <= 31)
            m = x << (31 - msb);
        else
            m = x >> (msb - 31);
        frac = '0;
        for (i = LOG_FRAC - 1; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                frac[i] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(msb) << LOG_FRAC) + frac;
    endfunction

    // 10*log10(num/den) in 1/256 dB: log2 difference times 2560*log10(2),
    // rounded half away from zero, clamped to +-40 dB.
    function automatic qual_t qual_of_base(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] ln, ld, diff, prod, mag;
        logic        neg;
        int          q;
        ln   = log2_q30(num);
        ld   = log2_q30(den);
        neg  = ln < ld;
        diff = neg ? ld - ln : ln - ld;
        prod = diff * 64'(DB_SCALE);
        mag  = (prod + (64'd1 << (SCALE_SHIFT - 1))) >> SCALE_SHIFT;
        if (mag > 64'(QUAL_LIMIT))
            mag = 64'(QUAL_LIMIT);
        q = neg ? -int'(mag) : int'(mag);
        return q[QUAL_W-1:0];
    endfunction

    function automatic qual_beat_t predict_quals(input prob_beat_t b);
        logic [63:0] raw [4];
        logic [63:0] av  [4];
        logic [63:0] floor_add, total;
        qual_beat_t  r;
        int          i;
        raw[0] = 64'(b.a);
        raw[1] = 64'(b.c);
        raw[2] = 64'(b.g);
        raw[3] = 64'(b.t);
        // 1e-3 floor, never zero so that both log arguments stay positive
        floor_add = (PROB_ONE + 64'(FLOOR_RND)) / 64'(FLOOR_DEN);
        if (floor_add == 0)
            floor_add = 64'd1;
        total = '0;
        for (i = 0; i < 4; i++) begin
            // probabilities above one saturate to one
            av[i] = ((raw[i] > PROB_ONE) ? PROB_ONE : raw[i]) + floor_add;
            total += av[i];
        end
        r.a = qual_of_base(av[0], total - av[0]);
        r.c = qual_of_base(av[1], total - av[1]);
        r.g = qual_of_base(av[2], total - av[2]);
        r.t = qual_of_base(av[3], total - av[3]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------
    prob_beat_t prob_pending_q [$];   // beats not yet presented
    qual_beat_t qual_expect_q  [$];   // predicted results, oldest first
    int         err_cnt    = 0;
    int         sent_cnt   = 0;       // beats taken off the pending queue
    int         pause_a    = -1;      // sender waits for a full drain here
    int         pause_b    = -1;
    logic       in_taken   = 1'b0;    // input beat accepted at last posedge

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Idle length for either side: mostly none or short, a few long, and
    // occasional stretches with no idling at all.
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge only
    // ------------------------------------------------------------------
    int send_gap   = 0;
    int send_burst = 0;

    always @(negedge aclk) begin
        logic       nxt_valid;
        prob_beat_t nxt_beat;
        logic       hold_drain;
        // a beat still waiting for s_ready stays put
        nxt_valid  = s_valid && !in_taken;
        nxt_beat   = cur_beat;
        hold_drain = (sent_cnt == pause_a || sent_cnt == pause_b)
                     && qual_expect_q.size() != 0;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!hold_drain && prob_pending_q.size() != 0) begin
                nxt_beat  = prob_pending_q.pop_front();
                nxt_valid = 1'b1;
                sent_cnt++;
                send_gap  = pick_gap(send_burst);
            end
        end
        s_valid  <= nxt_valid;
        cur_beat <= nxt_beat;
    end

    // Receiver backpressure, also on the falling edge
    int recv_stall = 0;
    int recv_burst = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
            recv_stall  = pick_gap(recv_burst);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        qual_beat_t exp_beat;
        qual_t      got  [4];
        qual_t      want [4];
        string      base [4];
        int         i;
        base    = '{"A", "C", "G", "T"};
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            qual_expect_q.push_back(predict_quals(cur_beat));
        if (aresetn && m_valid && m_ready) begin
            if (qual_expect_q.size() == 0) begin
                flag_error("result beat with no expectation pending");
            end else begin
                exp_beat = qual_expect_q.pop_front();
                got  = '{m_qual_a, m_qual_c, m_qual_g, m_qual_t};
                want = '{exp_beat.a, exp_beat.c, exp_beat.g, exp_beat.t};
                for (i = 0; i < 4; i++) begin
                    if (got[i] !== want[i])
                        flag_error($sformatf("qual_%s got %0d expected %0d",
                                             base[i], got[i], want[i]));
                end
            end
        end
    end

    // Watchdog: counts cycles without any accepted beat on either channel
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STUCK_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic [63:0] pa, input logic [63:0] pc,
                              input logic [63:0] pg, input logic [63:0] pt);
        prob_beat_t b;
        b.a = pa[PROB_W-1:0];
        b.c = pc[PROB_W-1:0];
        b.g = pg[PROB_W-1:0];
        b.t = pt[PROB_W-1:0];
        prob_pending_q.push_back(b);
    endtask

    initial begin
        logic [63:0] w [4];
        logic [63:0] wsum;
        logic [63:0] edge_vals [6];
        int          n, k, r, i;

        edge_vals = '{64'd0, 64'd1, PROB_ONE - 1, PROB_ONE, PROB_ONE + 1, FIELD_MAX};

        // Directed: all-zero and all-one, each base alone, the uniform case,
        // inputs above one (which must saturate), tiny values, bit patterns.
        queue_beat(0, 0, 0, 0);
        queue_beat(PROB_ONE, PROB_ONE, PROB_ONE, PROB_ONE);
        queue_beat(PROB_ONE, 0, 0, 0);
        queue_beat(0, PROB_ONE, 0, 0);
        queue_beat(0, 0, PROB_ONE, 0);
        queue_beat(0, 0, 0, PROB_ONE);
        queue_beat(PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4, PROB_ONE / 4);
        queue_beat(FIELD_MAX, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        queue_beat(PROB_ONE + 1, 0, 0, 0);
        queue_beat(FIELD_MAX, 0, 0, 0);
        queue_beat(0, 0, 0, FIELD_MAX);
        queue_beat(PROB_ONE - 1, 1, 0, 0);
        queue_beat(1, 1, 1, PROB_ONE - 3);
        queue_beat(PROB_ONE - 1, PROB_ONE, PROB_ONE + 1, FIELD_MAX);
        queue_beat(64'h15555, 64'h0AAAA, 64'h15555, 64'h0AAAA);
        queue_beat(64'h0AAAA, 64'h15555, 64'h0AAAA, 64'h15555);
        queue_beat(PROB_ONE / 2, PROB_ONE / 2, 0, 0);
        queue_beat(0, 1, 2, 3);
        queue_beat(PROB_ONE, PROB_ONE, 0, 0);

        // sender waits for an empty pipe after the directed part and midway
        pause_a = prob_pending_q.size();
        pause_b = pause_a + N_RANDOM / 2;

        for (n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // well-formed position: weights normalized to sum to one,
                // often with one dominant base as a called base would have
                wsum = '0;
                for (i = 0; i < 4; i++)
                    w[i] = 64'($urandom_range(0, 65536));
                if ($urandom_range(0, 1)) begin
                    k = $urandom_range(0, 3);
                    w[k] = w[k] * 64'($urandom_range(8, 256));
                end
                for (i = 0; i < 4; i++)
                    wsum += w[i];
                if (wsum == 0) begin
                    w    = '{64'd1, 64'd1, 64'd1, 64'd1};
                    wsum = 64'd4;
                end
                for (i = 0; i < 4; i++)
                    w[i] = (w[i] * PROB_ONE) / wsum;
            end else if (r < 75) begin
                // any 17-bit value, including far above one
                for (i = 0; i < 4; i++)
                    w[i] = 64'($urandom_range(0, 32'(FIELD_MAX)));
            end else if (r < 87) begin
                // values around zero and around one, and the field maximum
                for (i = 0; i < 4; i++)
                    w[i] = edge_vals[$urandom_range(0, 5)];
            end else begin
                for (i = 0; i < 4; i++)
                    w[i] = 64'($urandom_range(0, 32'(PROB_ONE)));
            end
            queue_beat(w[0], w[1], w[2], w[3]);
        end

        // single reset at the start of the run
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (prob_pending_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (qual_expect_q.size() != 0)
            @(posedge aclk);
        // any stray beat after the last expected one is flagged meanwhile
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_cnt == 0 && qual_expect_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
